/* src/hjds_pkg.sv */
// Shared types, constants and the integer mix step for the job dispatch stacks.
// Used by hjds_hash_unit and hashed_job_dispatch_stacks_top; depends on nothing.
package hjds_pkg;

    localparam int WORKERS     = 4;
    localparam int STACK_DEPTH = 128;
    localparam int DESC_W      = 12;
    localparam int WORKER_W    = $clog2(WORKERS);
    localparam int IDX_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = WORKER_W + IDX_W;
    localparam int MEM_DEPTH   = WORKERS * STACK_DEPTH;
    localparam int KEY_W       = 32;
    localparam int MOD_W       = 3;
    localparam int MIX_STEPS   = 6;
    localparam int STEP_W      = 3;
    localparam int BIT_W       = $clog2(KEY_W);

    localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(2);
    localparam logic [MOD_W-1:0] MOD_MAX   = MOD_W'(WORKERS);

    localparam logic OP_DISPATCH = 1'b0;
    localparam logic OP_POP      = 1'b1;

    typedef enum logic [2:0] {
        ST_QUEUED  = 3'd0,
        ST_ALREADY = 3'd1,
        ST_FULL    = 3'd2,
        ST_POPPED  = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] key;
        logic [MOD_W-1:0] divisor;
    } t_hash_req;

    typedef struct packed {
        logic                done;
        logic [WORKER_W-1:0] worker;
    } t_hash_rsp;

    function automatic logic [KEY_W-1:0] mix_step(input logic [KEY_W-1:0] k,
                                                  input logic [STEP_W-1:0] step);
        logic [KEY_W-1:0] res;
        case (step)
            3'd0:    res = k + ~(k << 15);
            3'd1:    res = k ^ (k >> 10);
            3'd2:    res = k + (k << 3);
            3'd3:    res = k ^ (k >> 6);
            3'd4:    res = k + ~(k << 11);
            3'd5:    res = k ^ (k >> 16);
            default: res = k;
        endcase
        return res;
    endfunction

endpackage

/* src/hjds_hash_unit.sv */
// Iterative hash and remainder unit: one mix step per cycle, then one quotient bit per cycle.
// Depends on hjds_pkg.
module hjds_hash_unit (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  hjds_pkg::t_hash_req    i_req,
    output hjds_pkg::t_hash_rsp    o_rsp
);

    typedef enum logic [2:0] {
        H_IDLE = 3'b001,
        H_MIX  = 3'b010,
        H_DIV  = 3'b100
    } t_hstate;

    t_hstate                              r_state;
    logic [hjds_pkg::KEY_W-1:0]           r_k;
    logic [hjds_pkg::STEP_W-1:0]          r_step;
    logic [hjds_pkg::BIT_W-1:0]           r_bit;
    logic [hjds_pkg::MOD_W-1:0]           r_div;
    logic [hjds_pkg::WORKER_W-1:0]        r_rem;
    logic                                 r_done;
    logic [hjds_pkg::WORKER_W:0]          n_trial;
    logic [hjds_pkg::WORKER_W:0]          n_rem;

    always_comb begin
        n_trial = {r_rem, r_k[hjds_pkg::KEY_W-1]};
        if (n_trial >= r_div) begin
            n_rem = n_trial - r_div;
        end else begin
            n_rem = n_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
            r_step  <= '0;
            r_bit   <= '0;
            r_rem   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                H_IDLE: begin
                    if (i_req.start) begin
                        r_k     <= i_req.key;
                        r_div   <= i_req.divisor;
                        r_step  <= '0;
                        r_state <= H_MIX;
                    end
                end
                H_MIX: begin
                    r_k <= hjds_pkg::mix_step(r_k, r_step);
                    if (r_step == hjds_pkg::STEP_W'(hjds_pkg::MIX_STEPS - 1)) begin
                        r_bit   <= '0;
                        r_rem   <= '0;
                        r_state <= H_DIV;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                H_DIV: begin
                    r_k   <= r_k << 1;
                    r_rem <= n_rem[hjds_pkg::WORKER_W-1:0];
                    r_bit <= r_bit + 1'b1;
                    if (r_bit == hjds_pkg::BIT_W'(hjds_pkg::KEY_W - 1)) begin
                        r_done  <= 1'b1;
                        r_state <= H_IDLE;
                    end
                end
                default: begin
                    r_state <= H_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.worker = r_rem;

endmodule

/* src/hashed_job_dispatch_stacks_top.sv */
// Top level of the hashed job dispatch stacks: sequencer, stack store and fill counts.
// Depends on hjds_pkg and hjds_hash_unit.
// A dispatch word hashes its descriptor, picks a worker by the remainder against the
// configured modulus, searches that worker's stack from newest to oldest entry and pushes
// the descriptor if it is absent and the stack has room. A dispatch first waits for the
// hash and remainder unit; the search then reads the single-port store one entry a cycle,
// at most n of them for a fill count n (up to 128). A pop takes the named worker's top
// entry, if any. One word is worked on at a time; a finished result waits in an output
// register while the next word is accepted. The store needs no clearing after reset.
module hashed_job_dispatch_stacks_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hjds_pkg::MOD_W-1:0]          i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_opcode,
    input  logic [hjds_pkg::DESC_W-1:0]         i_descriptor,
    input  logic [hjds_pkg::WORKER_W-1:0]       i_worker,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [2:0]                          o_status,
    output logic [hjds_pkg::WORKER_W-1:0]       o_chosen_worker,
    output logic [hjds_pkg::DESC_W-1:0]         o_popped_descriptor
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_HASH     = 7'b0000010,
        S_PREP     = 7'b0000100,
        S_SEARCH   = 7'b0001000,
        S_POP      = 7'b0010000,
        S_POP_DATA = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    t_state                                 r_state;
    logic [hjds_pkg::MOD_W-1:0]             r_cfg_mod;
    logic [hjds_pkg::DESC_W-1:0]            r_desc;
    logic [hjds_pkg::WORKER_W-1:0]          r_worker;
    logic [hjds_pkg::CNT_W-1:0]             r_count [hjds_pkg::WORKERS];
    logic [hjds_pkg::CNT_W-1:0]             r_ptr;
    logic                                   r_rd_vld;
    logic [hjds_pkg::DESC_W-1:0]            r_rd_data;
    logic [hjds_pkg::DESC_W-1:0]            r_mem [hjds_pkg::MEM_DEPTH];
    hjds_pkg::t_status                      r_res_status;
    logic [hjds_pkg::DESC_W-1:0]            r_res_desc;
    logic                                   r_out_vld;
    hjds_pkg::t_status                      r_out_status;
    logic [hjds_pkg::WORKER_W-1:0]          r_out_worker;
    logic [hjds_pkg::DESC_W-1:0]            r_out_desc;

    hjds_pkg::t_hash_req                    hash_req;
    hjds_pkg::t_hash_rsp                    hash_rsp;
    logic [hjds_pkg::MOD_W-1:0]             divisor_now;
    logic                                   in_accept;
    logic [hjds_pkg::CNT_W-1:0]             cnt_cur;
    logic [hjds_pkg::CNT_W-1:0]             ptr_dec;
    logic [hjds_pkg::CNT_W-1:0]             cnt_dec;
    logic                                   hit;
    logic                                   issue;
    logic                                   miss_done;
    logic                                   push_go;
    logic                                   pop_go;
    logic                                   rd_en;
    logic [hjds_pkg::ADDR_W-1:0]            rd_addr;
    logic                                   out_free;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        if (r_cfg_mod == '0) begin
            divisor_now = hjds_pkg::MOD_W'(1);
        end else if (r_cfg_mod > hjds_pkg::MOD_MAX) begin
            divisor_now = hjds_pkg::MOD_MAX;
        end else begin
            divisor_now = r_cfg_mod;
        end
    end

    assign hash_req.start   = in_accept && (i_opcode == hjds_pkg::OP_DISPATCH);
    assign hash_req.key     = {{(hjds_pkg::KEY_W - hjds_pkg::DESC_W){1'b0}}, i_descriptor};
    assign hash_req.divisor = divisor_now;

    hjds_hash_unit u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (hash_req),
        .o_rsp   (hash_rsp)
    );

    assign cnt_cur   = r_count[r_worker];
    assign ptr_dec   = r_ptr - 1'b1;
    assign cnt_dec   = cnt_cur - 1'b1;
    assign hit       = r_rd_vld && (r_rd_data == r_desc);
    assign issue     = (r_ptr != '0) && !hit;
    assign miss_done = !hit && (r_ptr == '0) && !r_rd_vld;
    assign push_go   = (r_state == S_SEARCH) && miss_done
                       && (cnt_cur < hjds_pkg::CNT_W'(hjds_pkg::STACK_DEPTH));
    assign pop_go    = (r_state == S_POP) && (cnt_cur != '0);
    assign rd_en     = ((r_state == S_SEARCH) && issue) || pop_go;
    assign out_free  = !r_out_vld || !i_out_stall;

    always_comb begin
        if (r_state == S_POP) begin
            rd_addr = {r_worker, cnt_dec[hjds_pkg::IDX_W-1:0]};
        end else begin
            rd_addr = {r_worker, ptr_dec[hjds_pkg::IDX_W-1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (push_go) begin
            r_mem[{r_worker, cnt_cur[hjds_pkg::IDX_W-1:0]}] <= r_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mod <= hjds_pkg::MOD_RESET;
        end else if (i_cfg_we) begin
            r_cfg_mod <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < hjds_pkg::WORKERS; w++) begin
                r_count[w] <= '0;
            end
        end else if (push_go) begin
            r_count[r_worker] <= cnt_cur + 1'b1;
        end else if ((r_state == S_POP_DATA)) begin
            r_count[r_worker] <= cnt_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_ptr     <= '0;
            r_worker  <= '0;
        end else begin
            r_rd_vld <= (r_state == S_SEARCH) && issue;
            if ((r_state == S_DONE) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_desc     <= i_descriptor;
                        r_worker   <= i_worker;
                        r_res_desc <= '0;
                        if (i_opcode == hjds_pkg::OP_DISPATCH) begin
                            r_state <= S_HASH;
                        end else begin
                            r_state <= S_POP;
                        end
                    end
                end
                S_HASH: begin
                    if (hash_rsp.done) begin
                        r_worker <= hash_rsp.worker;
                        r_state  <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_ptr   <= cnt_cur;
                    r_state <= S_SEARCH;
                end
                S_SEARCH: begin
                    if (hit) begin
                        r_res_status <= hjds_pkg::ST_ALREADY;
                        r_state      <= S_DONE;
                    end else if (miss_done) begin
                        r_res_status <= push_go ? hjds_pkg::ST_QUEUED : hjds_pkg::ST_FULL;
                        r_state      <= S_DONE;
                    end else if (issue) begin
                        r_ptr <= ptr_dec;
                    end
                end
                S_POP: begin
                    if (pop_go) begin
                        r_state <= S_POP_DATA;
                    end else begin
                        r_res_status <= hjds_pkg::ST_EMPTY;
                        r_state      <= S_DONE;
                    end
                end
                S_POP_DATA: begin
                    r_res_status <= hjds_pkg::ST_POPPED;
                    r_res_desc   <= r_rd_data;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_status <= r_res_status;
                        r_out_worker <= r_worker;
                        r_out_desc   <= r_res_desc;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid         = r_out_vld;
    assign o_status            = r_out_status;
    assign o_chosen_worker     = r_out_worker;
    assign o_popped_descriptor = r_out_desc;

    // No stack ever holds more than its depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_cur <= hjds_pkg::CNT_W'(hjds_pkg::STACK_DEPTH))
        else $error("stack fill count above depth");

    // An accepted word keeps the input stalled on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input not stalled after accept");

    // A push raises the chosen worker's fill count by one.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_go |=> (r_count[$past(r_worker)] == $past(cnt_cur) + 1'b1))
        else $error("push did not advance fill count");

    // Only a successful pop carries a nonzero descriptor.
    a_desc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_out_status != hjds_pkg::ST_POPPED)) |-> (o_popped_descriptor == '0))
        else $error("nonzero descriptor on a result other than pop");

    // The hash unit answers only while a dispatch waits for it.
    a_hash_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_rsp.done |-> (r_state == S_HASH))
        else $error("hash result outside the hash wait state");

endmodule

/* verif/hashed_job_dispatch_stacks_top_tb.sv */
// Self-checking testbench for hashed_job_dispatch_stacks_top: dispatch and pop words
// are checked against a scoreboard that keeps its own copy of the per-worker stacks.
// Depends on hjds_pkg and the hashed_job_dispatch_stacks_top RTL.
module hashed_job_dispatch_stacks_top_tb;

    localparam int LIMIT     = 3_000_000;
    localparam int SEGMENTS  = 9;
    localparam int SEG_WORDS = 220;

    typedef struct packed {
        hjds_pkg::t_status             status;
        logic [hjds_pkg::WORKER_W-1:0] worker;
        logic [hjds_pkg::DESC_W-1:0]   popped;
    } t_job_result;

    class dispatch_scoreboard;
        logic [hjds_pkg::DESC_W-1:0] stacks [hjds_pkg::WORKERS][hjds_pkg::STACK_DEPTH];
        int unsigned                 fill [hjds_pkg::WORKERS];
        logic [hjds_pkg::MOD_W-1:0]  modulus;
        t_job_result                 pending_results [$];
        int                          mismatches;

        function new();
            foreach (fill[i]) fill[i] = 0;
            modulus    = hjds_pkg::MOD_RESET;
            mismatches = 0;
        endfunction

        function logic [31:0] scramble(logic [31:0] k);
            k = k + ~(k << 15);
            k = k ^ (k >> 10);
            k = k + (k << 3);
            k = k ^ (k >> 6);
            k = k + ~(k << 11);
            k = k ^ (k >> 16);
            return k;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_word(logic op, logic [hjds_pkg::DESC_W-1:0] desc,
                                logic [hjds_pkg::WORKER_W-1:0] wsel);
            t_job_result r;
            logic [31:0] h;
            int unsigned div;
            int unsigned w;
            bit          found;
            r.popped = '0;
            if (op == hjds_pkg::OP_DISPATCH) begin
                div = (modulus == 0) ? 1 :
                      ((modulus > hjds_pkg::WORKERS) ? hjds_pkg::WORKERS : modulus);
                h = scramble({{(32-hjds_pkg::DESC_W){1'b0}}, desc});
                w = h % div;
                found = 1'b0;
                for (int i = 0; i < fill[w]; i++) begin
                    found = found || (stacks[w][i] == desc);
                end
                if (found) begin
                    r.status = hjds_pkg::ST_ALREADY;
                end else if (fill[w] >= hjds_pkg::STACK_DEPTH) begin
                    r.status = hjds_pkg::ST_FULL;
                end else begin
                    stacks[w][fill[w]] = desc;
                    fill[w]++;
                    r.status = hjds_pkg::ST_QUEUED;
                end
                r.worker = w[hjds_pkg::WORKER_W-1:0];
            end else begin
                w = wsel;
                r.worker = wsel;
                if (fill[w] == 0) begin
                    r.status = hjds_pkg::ST_EMPTY;
                end else begin
                    fill[w]--;
                    r.popped = stacks[w][fill[w]];
                    r.status = hjds_pkg::ST_POPPED;
                end
            end
            pending_results.push_back(r);
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_word(logic [2:0] status, logic [hjds_pkg::WORKER_W-1:0] worker,
                        logic [hjds_pkg::DESC_W-1:0] popped);
            t_job_result e;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected word, status %0d", status));
                return;
            end
            e = pending_results.pop_front();
            if (status !== e.status)
                report($sformatf("status %0d, expected %0d", status, e.status));
            if (worker !== e.worker)
                report($sformatf("chosen_worker %0d, expected %0d", worker, e.worker));
            if (popped !== e.popped)
                report($sformatf("popped_descriptor %0d, expected %0d", popped, e.popped));
        endtask
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [hjds_pkg::MOD_W-1:0]    i_cfg_wdata;
    logic                          i_in_valid;
    logic                          o_in_stall;
    logic                          i_opcode;
    logic [hjds_pkg::DESC_W-1:0]   i_descriptor;
    logic [hjds_pkg::WORKER_W-1:0] i_worker;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic [2:0]                    o_status;
    logic [hjds_pkg::WORKER_W-1:0] o_chosen_worker;
    logic [hjds_pkg::DESC_W-1:0]   o_popped_descriptor;

    int tx_idle_pct = 37;
    int rx_idle_pct = 56;
    int cycle_count;

    int seg_mod   [SEGMENTS] = '{4, 1, 0, 7, 3, 5, 6, 2, 1};
    int seg_disp  [SEGMENTS] = '{70, 92, 60, 50, 75, 40, 65, 55, 45};
    int seg_pool  [SEGMENTS] = '{4095, 4095, 127, 511, 255, 63, 1023, 31, 4095};

    dispatch_scoreboard sb = new();

    hashed_job_dispatch_stacks_top dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_opcode            (i_opcode),
        .i_descriptor        (i_descriptor),
        .i_worker            (i_worker),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_chosen_worker     (o_chosen_worker),
        .o_popped_descriptor (o_popped_descriptor)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_word(i_opcode, i_descriptor, i_worker);
            if (o_out_valid && !i_out_stall)
                sb.check_word(o_status, o_chosen_worker, o_popped_descriptor);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    task automatic send_word(input logic op, input logic [hjds_pkg::DESC_W-1:0] desc,
                             input logic [hjds_pkg::WORKER_W-1:0] wsel);
        int gap;
        gap = 0;
        if (tx_idle_pct > 0 && $urandom_range(0, 15) == 0)
            gap = $urandom_range(1, 200);
        while ($urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_descriptor <= desc;
        i_worker     <= wsel;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    task automatic write_modulus(input logic [hjds_pkg::MOD_W-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.modulus = value;
    endtask

    initial begin
        logic                          op;
        logic [hjds_pkg::DESC_W-1:0]   desc;
        logic [hjds_pkg::WORKER_W-1:0] wsel;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        i_in_valid   <= 1'b0;
        i_opcode     <= hjds_pkg::OP_DISPATCH;
        i_descriptor <= '0;
        i_worker     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pops of empty stacks, extreme descriptors, repeats and pops after pushes.
        for (int w = 0; w < hjds_pkg::WORKERS; w++)
            send_word(hjds_pkg::OP_POP, hjds_pkg::DESC_W'($urandom_range(0, 4095)),
                      hjds_pkg::WORKER_W'(w));
        send_word(hjds_pkg::OP_DISPATCH, 12'd0, 2'd3);
        send_word(hjds_pkg::OP_DISPATCH, 12'd4095, 2'd0);
        send_word(hjds_pkg::OP_DISPATCH, 12'd0, 2'd1);
        send_word(hjds_pkg::OP_DISPATCH, 12'd4095, 2'd2);
        send_word(hjds_pkg::OP_DISPATCH, 12'd1, 2'd0);
        send_word(hjds_pkg::OP_DISPATCH, 12'hAAA, 2'd3);
        send_word(hjds_pkg::OP_DISPATCH, 12'h555, 2'd0);
        send_word(hjds_pkg::OP_DISPATCH, 12'h800, 2'd1);
        send_word(hjds_pkg::OP_DISPATCH, 12'h7FF, 2'd2);
        send_word(hjds_pkg::OP_DISPATCH, 12'd1, 2'd3);
        for (int w = 0; w < hjds_pkg::WORKERS; w++)
            send_word(hjds_pkg::OP_POP, 12'hFFF, hjds_pkg::WORKER_W'(w));
        send_word(hjds_pkg::OP_POP, 12'd0, 2'd0);
        send_word(hjds_pkg::OP_POP, 12'd0, 2'd1);
        send_word(hjds_pkg::OP_DISPATCH, 12'd0, 2'd0);

        for (int s = 0; s < SEGMENTS; s++) begin
            if (s < 3) begin
                tx_idle_pct = 37;
                rx_idle_pct = 56;
            end else if (s < 6) begin
                tx_idle_pct = 56;
                rx_idle_pct = 37;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_modulus(hjds_pkg::MOD_W'(seg_mod[s]));
            for (int n = 0; n < SEG_WORDS; n++) begin
                op = ($urandom_range(0, 99) < seg_disp[s]) ? hjds_pkg::OP_DISPATCH
                                                           : hjds_pkg::OP_POP;
                if ($urandom_range(0, 3) == 0)
                    desc = hjds_pkg::DESC_W'($urandom_range(0, 4095));
                else
                    desc = hjds_pkg::DESC_W'($urandom_range(0, seg_pool[s]));
                wsel = hjds_pkg::WORKER_W'($urandom_range(0, hjds_pkg::WORKERS - 1));
                if ($urandom_range(0, 199) == 0)
                    wait_drained();
                send_word(op, desc, wsel);
            end
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
src/hjds_pkg.sv
src/hjds_hash_unit.sv
src/hashed_job_dispatch_stacks_top.sv
verif/hashed_job_dispatch_stacks_top_tb.sv
